FILE: rtl/assert_macros.svh
// Assertion helpers shared by the files that check their own logic.
// Each macro samples on clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/ialist_pkg.sv
package ialist_pkg;

  localparam int OP_W      = 3;
  localparam int POS_W     = 6;
  localparam int VAL_W     = 32;
  localparam int STATUS_W  = 2;
  localparam int RIDX_W    = 5;
  localparam int NLEN_W    = 6;
  // Widest index and count for the largest supported list (256 entries).
  localparam int IDX_MAX_W = 8;
  localparam int LEN_MAX_W = 9;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND  = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE  = 3'd3;
  localparam logic [OP_W-1:0] OP_MIN     = 3'd4;
  localparam logic [OP_W-1:0] OP_MAX     = 3'd5;
  localparam logic [OP_W-1:0] OP_DEL_MIN = 3'd6;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_INSERT,
    CELL_DELETE
  } cell_op_t;

  typedef struct packed {
    cell_op_t               kind;
    logic [IDX_MAX_W-1:0]   target;
    val_t                   value;
  } cell_cmd_t;

  typedef enum logic [1:0] {
    SCAN_MIN,
    SCAN_MAX,
    SCAN_PICK
  } scan_mode_t;

  typedef struct packed {
    scan_mode_t             mode;
    logic [IDX_MAX_W-1:0]   pick;
    val_t                   best_val;
    logic [IDX_MAX_W-1:0]   best_idx;
  } token_body_t;

  typedef struct packed {
    logic        valid;
    token_body_t body;
  } token_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [RIDX_W-1:0]   index;
    val_t                value;
    logic [NLEN_W-1:0]   length;
  } result_t;

endpackage

FILE: rtl/ialist_if.sv
interface ialist_cmd_if;
  logic                                 valid;
  logic                                 ready;
  logic [ialist_pkg::OP_W-1:0]          opcode;
  logic [ialist_pkg::POS_W-1:0]         position;
  logic signed [ialist_pkg::VAL_W-1:0]  value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink (input valid, opcode, position, value, output ready);
endinterface

interface ialist_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic [ialist_pkg::STATUS_W-1:0]      status;
  logic [ialist_pkg::RIDX_W-1:0]        result_index;
  logic signed [ialist_pkg::VAL_W-1:0]  result_value;
  logic [ialist_pkg::NLEN_W-1:0]        new_length;

  modport source (output valid, status, result_index, result_value, new_length,
                  input ready);
  modport sink (input valid, status, result_index, result_value, new_length,
                output ready);
endinterface

FILE: rtl/indexed_array_list_engine_core.sv
// Ordered list engine: up to CAPACITY signed 32-bit entries with a length count.
// Commands arrive as words on the cmd channel (opcode, position, value) and each
// one returns exactly one word on the rsp channel (status, result_index,
// result_value, new_length). Both channels move a word when valid and ready
// are high at the same rising edge.
// Clear, append, insert and the undefined opcode finish in the cycle they are
// accepted; their response is written into the response queue, and a new
// command can be taken every cycle while that queue has room. A delete at
// index, find min, find max or delete min on a non-empty list sends a token
// down the row of cells, one cell per cycle, and the response is pushed when
// the token leaves the last cell; cmd.ready stays low meanwhile. Those commands
// answer at once when the list is empty or the index is out of range.
// A two-word response queue sits in front of rsp, so a stalled receiver does
// not block the next command until a second response is waiting behind it.
// Reset (rst, synchronous) empties the list and the queue; entry contents are
// not cleared and are only read below the current length.
`include "assert_macros.svh"

module indexed_array_list_engine_core #(
  parameter int CAPACITY = 32
) (
  input  logic        clk,
  input  logic        rst,
  ialist_cmd_if.sink  cmd,
  ialist_rsp_if.source rsp
);

  localparam int LW = $clog2(CAPACITY + 1);
  localparam int CW = (LW > ialist_pkg::POS_W) ? LW : ialist_pkg::POS_W;
  localparam int IW = ialist_pkg::IDX_MAX_W;

  ialist_pkg::state_t    state;
  ialist_pkg::state_t    state_next;
  logic [LW-1:0]         length;
  logic [LW-1:0]         length_next;
  logic                  scan_del;
  logic                  scan_del_next;

  ialist_pkg::cell_cmd_t cell_cmd;
  ialist_pkg::token_t    head;
  ialist_pkg::token_t    tok [CAPACITY+1];
  ialist_pkg::val_t      entry [CAPACITY];
  logic [CAPACITY-1:0]   tok_valids;

  logic                  accept;
  logic                  q_full;
  logic                  push;
  ialist_pkg::result_t   res;
  logic                  is_full;
  logic                  is_empty;
  logic [CW-1:0]         pos_c;
  logic [CW-1:0]         len_c;
  ialist_pkg::token_t    tail;

  assign cmd.ready = (state == ialist_pkg::ST_IDLE) && !q_full;
  assign accept    = cmd.valid && cmd.ready;
  assign is_full   = (length == LW'(CAPACITY));
  assign is_empty  = (length == '0);
  assign pos_c     = CW'(cmd.position);
  assign len_c     = CW'(length);
  assign tok[0]    = head;
  assign tail      = tok[CAPACITY];

  // Command decode. Single-step commands act on the cells right away; the
  // others inject a scan token at the head of the row and wait for it at the tail.
  always_comb begin
    state_next      = state;
    length_next     = length;
    scan_del_next   = scan_del;
    cell_cmd.kind   = ialist_pkg::CELL_HOLD;
    cell_cmd.target = '0;
    cell_cmd.value  = cmd.value;
    head.valid         = 1'b0;
    head.body.mode     = ialist_pkg::SCAN_MIN;
    head.body.pick     = '0;
    head.body.best_val = entry[0];
    head.body.best_idx = '0;
    push         = 1'b0;
    res.status   = ialist_pkg::STATUS_OK;
    res.index    = '0;
    res.value    = '0;
    res.length   = ialist_pkg::NLEN_W'(length);

    unique case (state)
      ialist_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd.opcode)
            ialist_pkg::OP_CLEAR: begin
              push        = 1'b1;
              length_next = '0;
              res.length  = '0;
            end
            ialist_pkg::OP_APPEND: begin
              push = 1'b1;
              if (is_full) begin
                res.status = ialist_pkg::STATUS_FULL;
              end else begin
                cell_cmd.kind   = ialist_pkg::CELL_WRITE;
                cell_cmd.target = IW'(length);
                length_next     = length + LW'(1);
                res.index       = ialist_pkg::RIDX_W'(length);
                res.value       = cmd.value;
                res.length      = ialist_pkg::NLEN_W'(length + LW'(1));
              end
            end
            ialist_pkg::OP_INSERT: begin
              push = 1'b1;
              if (is_full) begin
                res.status = ialist_pkg::STATUS_FULL;
              end else if (pos_c > len_c) begin
                res.status = ialist_pkg::STATUS_RANGE;
              end else begin
                cell_cmd.kind   = ialist_pkg::CELL_INSERT;
                cell_cmd.target = IW'(cmd.position);
                length_next     = length + LW'(1);
                res.index       = ialist_pkg::RIDX_W'(cmd.position);
                res.value       = cmd.value;
                res.length      = ialist_pkg::NLEN_W'(length + LW'(1));
              end
            end
            ialist_pkg::OP_DELETE: begin
              if (is_empty) begin
                push       = 1'b1;
                res.status = ialist_pkg::STATUS_EMPTY;
              end else if (pos_c >= len_c) begin
                push       = 1'b1;
                res.status = ialist_pkg::STATUS_RANGE;
              end else begin
                // Fetch the doomed entry with a pick token, then shift down.
                head.valid     = 1'b1;
                head.body.mode = ialist_pkg::SCAN_PICK;
                head.body.pick = IW'(cmd.position);
                head.body.best_val = '0;
                head.body.best_idx = IW'(cmd.position);
                scan_del_next    = 1'b1;
                state_next       = ialist_pkg::ST_SCAN;
              end
            end
            ialist_pkg::OP_MIN, ialist_pkg::OP_MAX, ialist_pkg::OP_DEL_MIN: begin
              if (is_empty) begin
                push       = 1'b1;
                res.status = ialist_pkg::STATUS_EMPTY;
              end else begin
                // Strict compares keep the lowest index on ties.
                head.valid     = 1'b1;
                head.body.mode = (cmd.opcode == ialist_pkg::OP_MAX) ?
                                 ialist_pkg::SCAN_MAX : ialist_pkg::SCAN_MIN;
                scan_del_next    = (cmd.opcode == ialist_pkg::OP_DEL_MIN);
                state_next       = ialist_pkg::ST_SCAN;
              end
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      ialist_pkg::ST_SCAN: begin
        if (tail.valid) begin
          push       = 1'b1;
          res.index  = ialist_pkg::RIDX_W'(tail.body.best_idx);
          res.value  = tail.body.best_val;
          state_next = ialist_pkg::ST_IDLE;
          if (scan_del) begin
            cell_cmd.kind   = ialist_pkg::CELL_DELETE;
            cell_cmd.target = tail.body.best_idx;
            length_next     = length - LW'(1);
            res.length      = ialist_pkg::NLEN_W'(length - LW'(1));
          end
        end
      end
      default: begin
        state_next = ialist_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ialist_pkg::ST_IDLE;
      length   <= '0;
      scan_del <= 1'b0;
    end else begin
      state    <= state_next;
      length   <= length_next;
      scan_del <= scan_del_next;
    end
  end

  // The row of cells. Cell i holds entry i and token stage i.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ialist_pkg::val_t prev_e;
    ialist_pkg::val_t next_e;

    if (i == 0) begin : g_first
      assign prev_e = entry[i];
    end else begin : g_mid_prev
      assign prev_e = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_e = entry[i];
    end else begin : g_mid_next
      assign next_e = entry[i+1];
    end

    ialist_cell #(
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .cmd        (cell_cmd),
      .length     (ialist_pkg::LEN_MAX_W'(length)),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (entry[i]),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1])
    );

    assign tok_valids[i] = tok[i+1].valid;
  end

  ialist_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (q_full),
    .rsp       (rsp)
  );

  // The list never grows beyond its capacity.
  `ASSERT_IMPL(a_len_bound, 1'b1, length <= LW'(CAPACITY))
  // At most one scan token travels the row at a time.
  `ASSERT_IMPL(a_one_token, 1'b1, $onehot0(tok_valids))
  // A token only reaches the tail while the controller waits for it.
  `ASSERT_IMPL(a_tail_in_scan, tail.valid, state == ialist_pkg::ST_SCAN)
  // A clear empties the list by the next cycle.
  `ASSERT_NEXT(a_clear_len, accept && (cmd.opcode == ialist_pkg::OP_CLEAR), length == '0)

endmodule

FILE: rtl/ialist_cell.sv
module ialist_cell #(
  parameter int INDEX = 0
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  ialist_pkg::cell_cmd_t                 cmd,
  input  logic [ialist_pkg::LEN_MAX_W-1:0]      length,
  input  ialist_pkg::val_t                      prev_entry,
  input  ialist_pkg::val_t                      next_entry,
  output ialist_pkg::val_t                      entry,
  input  ialist_pkg::token_t                    tok_in,
  output ialist_pkg::token_t                    tok_out
);

  localparam logic [ialist_pkg::IDX_MAX_W-1:0] MY_IDX = ialist_pkg::IDX_MAX_W'(INDEX);

  logic                    at;
  logic                    above;
  logic                    live;
  logic                    take;
  logic                    tok_valid;
  ialist_pkg::token_body_t tok_body;
  ialist_pkg::token_body_t tok_body_next;

  assign at    = (cmd.target == MY_IDX);
  assign above = (MY_IDX > cmd.target);
  assign live  = (ialist_pkg::LEN_MAX_W'(INDEX) < length);

  // Entries shift as a whole row: each cell looks only at its neighbors.
  always_ff @(posedge clk) begin
    unique case (cmd.kind)
      ialist_pkg::CELL_HOLD: begin
      end
      ialist_pkg::CELL_WRITE: begin
        if (at) entry <= cmd.value;
      end
      ialist_pkg::CELL_INSERT: begin
        if (at) entry <= cmd.value;
        else if (above) entry <= prev_entry;
      end
      ialist_pkg::CELL_DELETE: begin
        if (at || above) entry <= next_entry;
      end
      default: begin
      end
    endcase
  end

  // The scan token picks up this live entry when it beats the best so far, or when this is the picked index.
  always_comb begin
    unique case (tok_in.body.mode)
      ialist_pkg::SCAN_MIN:  take = live && (entry < tok_in.body.best_val);
      ialist_pkg::SCAN_MAX:  take = live && (entry > tok_in.body.best_val);
      ialist_pkg::SCAN_PICK: take = live && (tok_in.body.pick == MY_IDX);
      default:               take = 1'b0;
    endcase
  end

  always_comb begin
    tok_body_next = tok_in.body;
    if (take) begin
      tok_body_next.best_val = entry;
      tok_body_next.best_idx = MY_IDX;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_valid <= 1'b0;
    end else begin
      tok_valid <= tok_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    tok_body <= tok_body_next;
  end

  assign tok_out.valid = tok_valid;
  assign tok_out.body  = tok_body;

endmodule

FILE: rtl/ialist_outq.sv
module ialist_outq (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  ialist_pkg::result_t push_data,
  output logic                full,
  ialist_rsp_if.source        rsp
);

  logic                out_valid;
  logic                out_valid_next;
  ialist_pkg::result_t out_data;
  logic                hold_valid;
  logic                hold_valid_next;
  ialist_pkg::result_t hold_data;
  logic                pop;
  logic                load_out;
  logic                load_hold;

  assign pop       = out_valid && rsp.ready;
  assign load_out  = pop ? (hold_valid || push) : (push && !out_valid);
  assign load_hold = push && (pop ? hold_valid : out_valid);

  always_comb begin
    out_valid_next  = pop ? (hold_valid || push) : (out_valid || push);
    hold_valid_next = load_hold ? 1'b1 : (pop ? 1'b0 : hold_valid);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      out_valid  <= out_valid_next;
      hold_valid <= hold_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data <= (pop && hold_valid) ? hold_data : push_data;
    if (load_hold) hold_data <= push_data;
  end

  assign full             = hold_valid;
  assign rsp.valid        = out_valid;
  assign rsp.status       = out_data.status;
  assign rsp.result_index = out_data.index;
  assign rsp.result_value = out_data.value;
  assign rsp.new_length   = out_data.length;

endmodule

FILE: dv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import ialist_pkg::*;

  // The list depth that the engine is built with. Scan commands walk the whole
  // row of cells, so it also sets the longest latency of one command.
  localparam int LIST_DEPTH = 32;
  localparam int RANDOM_WORDS = 1800;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int DRAIN_CYCLES = LIST_DEPTH + 8;
  localparam int MAX_SHOWN = 10;

  // Opcode 7 has no meaning; the engine must answer it with a plain OK and
  // leave the list alone.
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

  localparam val_t VAL_TOP = val_t'(32'h7fff_ffff);
  localparam val_t VAL_BOTTOM = val_t'(32'h8000_0000);

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    val_t             val;
  } list_cmd_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ialist_cmd_if cmd_ch ();
  ialist_rsp_if rsp_ch ();

  indexed_array_list_engine_core #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Commands waiting to be sent, and the replies that the accepted ones owe.
  list_cmd_t cmd_backlog[$];
  result_t   due_replies[$];
  list_cmd_t next_cmd;
  int        total_cmds = 0;
  int        words_taken = 0;
  int        replies_seen = 0;
  int        error_count = 0;

  // Length as the stimulus generator sees it. The length after a command
  // depends only on the opcode, the position and the old length, so the
  // generator can steer positions toward legal ones without the entry values.
  int gen_len = 0;

  // Shadow copy of the list used to work out each reply.
  val_t shadow_list[LIST_DEPTH];
  int   shadow_len = 0;

  // ---------------------------------------------------------------------------
  // Reply prediction.
  // ---------------------------------------------------------------------------

  // Index of the first minimum (or first maximum): strict compares keep the
  // lowest index on a tie.
  function automatic int first_extreme(bit want_max);
    int best;
    best = 0;
    for (int i = 1; i < shadow_len; i++) begin
      if (want_max ? (shadow_list[i] > shadow_list[best])
                   : (shadow_list[i] < shadow_list[best]))
        best = i;
    end
    return best;
  endfunction

  // Removes one entry and closes the hole; returns the value that left.
  function automatic val_t take_entry(int at);
    val_t gone;
    gone = shadow_list[at];
    for (int i = at; i < shadow_len - 1; i++)
      shadow_list[i] = shadow_list[i + 1];
    shadow_len--;
    return gone;
  endfunction

  // Applies one command to the shadow list and returns the reply it causes.
  // Any failing command leaves index and value at zero and the list as is.
  function automatic result_t apply_list_cmd(logic [OP_W-1:0] op,
                                             logic [POS_W-1:0] pos, val_t val);
    result_t r;
    int      at;
    r = '0;
    r.status = STATUS_OK;
    case (op)
      OP_CLEAR: begin
        shadow_len = 0;
      end
      OP_APPEND: begin
        if (shadow_len >= LIST_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          r.index = RIDX_W'(shadow_len);
          r.value = val;
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_INSERT: begin
        // Fullness is judged before the position.
        if (shadow_len >= LIST_DEPTH) begin
          r.status = STATUS_FULL;
        end else if (pos > shadow_len) begin
          r.status = STATUS_RANGE;
        end else begin
          for (int i = shadow_len; i > pos; i--)
            shadow_list[i] = shadow_list[i - 1];
          shadow_list[pos] = val;
          shadow_len++;
          r.index = RIDX_W'(pos);
          r.value = val;
        end
      end
      OP_DELETE: begin
        if (shadow_len == 0) begin
          r.status = STATUS_EMPTY;
        end else if (pos >= shadow_len) begin
          r.status = STATUS_RANGE;
        end else begin
          r.index = RIDX_W'(pos);
          r.value = take_entry(pos);
        end
      end
      OP_MIN, OP_MAX: begin
        if (shadow_len == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          at = first_extreme(op == OP_MAX);
          r.index = RIDX_W'(at);
          r.value = shadow_list[at];
        end
      end
      OP_DEL_MIN: begin
        if (shadow_len == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          at = first_extreme(1'b0);
          r.index = RIDX_W'(at);
          r.value = take_entry(at);
        end
      end
      default: begin
      end
    endcase
    r.length = NLEN_W'(shadow_len);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Values lean on the extremes and on a narrow band around zero, so that
  // ties in the min and max searches come up often.
  function automatic val_t pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    case (r)
      0: return VAL_TOP;
      1: return VAL_BOTTOM;
      2, 3: return val_t'(int'($urandom_range(0, 4)) - 2);
      default: return val_t'($urandom());
    endcase
  endfunction

  // Mostly a legal insert position; now and then one past the legal range, up to 63.
  function automatic logic [POS_W-1:0] insert_spot(int len);
    if ($urandom_range(0, 9) == 0)
      return POS_W'($urandom_range(len + 1, 63));
    return POS_W'($urandom_range(0, len));
  endfunction

  function automatic logic [POS_W-1:0] delete_spot(int len);
    if (len == 0 || $urandom_range(0, 9) == 0)
      return POS_W'($urandom_range(len, 63));
    return POS_W'($urandom_range(0, len - 1));
  endfunction

  function automatic logic [POS_W-1:0] any_spot();
    return POS_W'($urandom_range(0, 63));
  endfunction

  task automatic add_cmd(logic [OP_W-1:0] op, logic [POS_W-1:0] pos, val_t val);
    list_cmd_t c;
    c.op = op;
    c.pos = pos;
    c.val = val;
    cmd_backlog.push_back(c);
    case (op)
      OP_CLEAR: gen_len = 0;
      OP_APPEND: if (gen_len < LIST_DEPTH) gen_len++;
      OP_INSERT: if (gen_len < LIST_DEPTH && pos <= gen_len) gen_len++;
      OP_DELETE: if (gen_len > 0 && pos < gen_len) gen_len--;
      OP_DEL_MIN: if (gen_len > 0) gen_len--;
      default: begin
      end
    endcase
  endtask

  // One command of any kind, weighted so the length wanders over its range.
  task automatic add_mixed();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) add_cmd(OP_APPEND, any_spot(), pick_value());
    else if (r < 45) add_cmd(OP_INSERT, insert_spot(gen_len), pick_value());
    else if (r < 63) add_cmd(OP_DELETE, delete_spot(gen_len), pick_value());
    else if (r < 72) add_cmd(OP_MIN, any_spot(), pick_value());
    else if (r < 81) add_cmd(OP_MAX, any_spot(), pick_value());
    else if (r < 94) add_cmd(OP_DEL_MIN, any_spot(), pick_value());
    else if (r < 97) add_cmd(OP_UNUSED, any_spot(), pick_value());
    else add_cmd(OP_CLEAR, any_spot(), pick_value());
  endtask

  // Grows the list to capacity, then pushes against the full list and searches it.
  task automatic add_fill_run();
    while (gen_len < LIST_DEPTH) begin
      if ($urandom_range(0, 1) == 0)
        add_cmd(OP_APPEND, any_spot(), pick_value());
      else
        add_cmd(OP_INSERT, POS_W'($urandom_range(0, gen_len)), pick_value());
    end
    repeat ($urandom_range(1, 3)) begin
      if ($urandom_range(0, 1) == 0)
        add_cmd(OP_APPEND, any_spot(), pick_value());
      else
        add_cmd(OP_INSERT, any_spot(), pick_value());
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1) == 0)
        add_cmd(OP_MIN, any_spot(), pick_value());
      else
        add_cmd(OP_MAX, any_spot(), pick_value());
    end
  endtask

  // Shrinks the list to nothing, then asks things of the empty list.
  task automatic add_drain_run();
    while (gen_len > 0) begin
      if ($urandom_range(0, 1) == 0)
        add_cmd(OP_DELETE, POS_W'($urandom_range(0, gen_len - 1)), pick_value());
      else
        add_cmd(OP_DEL_MIN, any_spot(), pick_value());
    end
    repeat ($urandom_range(1, 3)) begin
      case ($urandom_range(0, 3))
        0: add_cmd(OP_DELETE, any_spot(), pick_value());
        1: add_cmd(OP_MIN, any_spot(), pick_value());
        2: add_cmd(OP_MAX, any_spot(), pick_value());
        default: add_cmd(OP_DEL_MIN, any_spot(), pick_value());
      endcase
    end
  endtask

  // Pauses: most short, a few long, none at all while the side is calm.
  function automatic int draw_pause(bit calm);
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Cycle count, calm stretches and the timeout.
  // ---------------------------------------------------------------------------

  int cycle_count = 0;
  bit src_calm = 1'b0;
  bit snk_calm = 1'b0;

  // Each side decides afresh, on a draw, whether to run without pauses,
  // which gives long back-to-back stretches between the ragged ones.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count % 256 == 0) begin
      src_calm <= ($urandom_range(0, 3) == 0);
      snk_calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d of %0d words taken, %0d replies due",
               cycle_count, words_taken, total_cmds, due_replies.size());
      $display("FAILURE");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Command driver. A word is taken at an edge where valid and ready are both
  // high; the prediction is made right there, from the word as it stood on the
  // channel, so the shadow list follows the engine in acceptance order.
  // ---------------------------------------------------------------------------

  int src_gap = 0;

  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) begin
        due_replies.push_back(apply_list_cmd(cmd_ch.opcode, cmd_ch.position,
                                             cmd_ch.value));
        words_taken++;
      end
      // The channel is free when nothing is shown or the shown word just went.
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          cmd_ch.valid <= 1'b0;
        end else if (cmd_backlog.size() > 0) begin
          next_cmd = cmd_backlog.pop_front();
          cmd_ch.valid <= 1'b1;
          cmd_ch.opcode <= next_cmd.op;
          cmd_ch.position <= next_cmd.pos;
          cmd_ch.value <= next_cmd.val;
          src_gap <= draw_pause(src_calm);
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Reply monitor. Ready is held low for a drawn stall after each high cycle;
  // every word that moves is compared with the oldest reply still owed.
  // ---------------------------------------------------------------------------

  int snk_hold = 0;
  result_t want;

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      snk_hold <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        replies_seen++;
        if (due_replies.size() == 0) begin
          error_count++;
          if (error_count <= MAX_SHOWN)
            $display("reply %0d arrived with none owed: status=%0d index=%0d value=%0d length=%0d",
                     replies_seen, rsp_ch.status, rsp_ch.result_index,
                     rsp_ch.result_value, rsp_ch.new_length);
        end else begin
          want = due_replies.pop_front();
          if (rsp_ch.status !== want.status || rsp_ch.result_index !== want.index ||
              rsp_ch.result_value !== want.value ||
              rsp_ch.new_length !== want.length) begin
            error_count++;
            if (error_count <= MAX_SHOWN) begin
              $display("reply %0d mismatch: expected status=%0d index=%0d value=%0d length=%0d",
                       replies_seen, want.status, want.index, want.value, want.length);
              $display("                    actual   status=%0d index=%0d value=%0d length=%0d",
                       rsp_ch.status, rsp_ch.result_index, rsp_ch.result_value,
                       rsp_ch.new_length);
            end
          end
        end
      end
      if (snk_hold > 0) begin
        snk_hold <= snk_hold - 1;
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
        snk_hold <= draw_pause(snk_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and the verdict.
  // ---------------------------------------------------------------------------

  initial begin
    int unsigned pick;

    cmd_ch.valid = 1'b0;
    cmd_ch.opcode = OP_CLEAR;
    cmd_ch.position = '0;
    cmd_ch.value = '0;
    rsp_ch.ready = 1'b0;

    // Directed opening. Every search and delete first meets an empty list,
    // then a short list is built with the extreme values, and duplicates of
    // both the minimum and the maximum so the lowest index must win the tie.
    add_cmd(OP_MIN, 6'd0, '0);
    add_cmd(OP_MAX, 6'd0, '0);
    add_cmd(OP_DELETE, 6'd0, '0);
    add_cmd(OP_DEL_MIN, 6'd0, '0);
    add_cmd(OP_INSERT, 6'd1, val_t'(5));        // past the end of an empty list
    add_cmd(OP_INSERT, 6'd0, val_t'(7));
    add_cmd(OP_APPEND, 6'd63, VAL_TOP);
    add_cmd(OP_APPEND, 6'd0, VAL_BOTTOM);
    add_cmd(OP_APPEND, 6'd0, VAL_BOTTOM);
    add_cmd(OP_APPEND, 6'd0, VAL_TOP);
    add_cmd(OP_APPEND, 6'd0, val_t'(-1));
    add_cmd(OP_APPEND, 6'd0, val_t'(0));
    add_cmd(OP_MIN, 6'd63, VAL_TOP);
    add_cmd(OP_MAX, 6'd63, VAL_BOTTOM);
    add_cmd(OP_INSERT, 6'd7, val_t'(42));       // at the very end
    add_cmd(OP_INSERT, 6'd3, val_t'(-5));       // in the middle
    add_cmd(OP_INSERT, 6'd63, val_t'(9));       // far out of range
    add_cmd(OP_DELETE, 6'd9, '0);               // exactly at the length
    add_cmd(OP_DELETE, 6'd63, '0);
    add_cmd(OP_DELETE, 6'd0, '0);
    add_cmd(OP_DEL_MIN, 6'd0, '0);
    add_cmd(OP_UNUSED, 6'd63, val_t'(-1));
    add_cmd(OP_CLEAR, 6'd63, val_t'(-1));
    add_cmd(OP_MIN, 6'd0, '0);

    // Random part: a mix of single commands and runs that fill the list to
    // capacity or drain it to nothing, so the full and empty edges are
    // crossed many times with random contents.
    while (cmd_backlog.size() < RANDOM_WORDS + 24) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        repeat ($urandom_range(1, 8)) add_mixed();
      end else if (pick < 78) begin
        add_fill_run();
      end else begin
        add_drain_run();
      end
    end
    total_cmds = cmd_backlog.size();

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to be taken and every reply to come back, then give
    // the engine one full scan time more so a stray reply would still show.
    while (words_taken < total_cmds || due_replies.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d bad replies out of %0d", error_count, replies_seen);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
